FILE: hdl/lst_pkg.sv
// ----------------------------------------------------------------------------
// lst_pkg - shared definitions for the line sensor tracker
// Widths, command and register codes, position and direction codes, and the
// configuration and status bundles passed between modules.
// ----------------------------------------------------------------------------
package lst_pkg;

  // Default widths for the top level parameters
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF  = 8;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int TIME_W   = 32;
  localparam int THRESH_W = 14;
  localparam int OFFSET_W = 13;
  localparam int DEB_W    = 16;
  localparam int POS_W    = 2;
  localparam int DIR_W    = 2;
  localparam int REG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Commands
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP   = 2'd2;

  // Line position codes
  localparam logic [POS_W-1:0] POS_MIDDLE = 2'd0;
  localparam logic [POS_W-1:0] POS_LEFT   = 2'd1;
  localparam logic [POS_W-1:0] POS_RIGHT  = 2'd2;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT    = 2'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT   = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LOST    = 2'd3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_MIN = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_MAX = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_LEFT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_MIDDLE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_RIGHT  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd5;

  // Register reset values
  localparam logic [THRESH_W-1:0] THRESHOLD_MIN_RST = 14'd0;
  localparam logic [THRESH_W-1:0] THRESHOLD_MAX_RST = 14'd4095;

  typedef struct packed {
    logic signed [THRESH_W-1:0] threshold_min;
    logic signed [THRESH_W-1:0] threshold_max;
    logic signed [OFFSET_W-1:0] offset_left;
    logic signed [OFFSET_W-1:0] offset_middle;
    logic signed [OFFSET_W-1:0] offset_right;
    logic [DEB_W-1:0]           debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       active_flags;
    logic [POS_W-1:0] line_position;
    logic [DIR_W-1:0] direction;
    logic             on_line;
    logic             crossed;
    logic             counting;
    logic             target_reached;
  } status_t;

endpackage

FILE: hdl/lst_window.sv
// ----------------------------------------------------------------------------
// lst_window - offset and window compare for one sensor
// Adds the signed offset to the converter code and checks the exact sum
// against the inclusive signed window.
// ----------------------------------------------------------------------------
module lst_window #(
  parameter int SAMPLE_BITS = lst_pkg::SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0]              code,
  input  logic signed [lst_pkg::OFFSET_W-1:0] offset,
  input  logic signed [lst_pkg::THRESH_W-1:0] threshold_min,
  input  logic signed [lst_pkg::THRESH_W-1:0] threshold_max,
  output logic                                active
);

  // wide enough for the exact sum and for the thresholds
  localparam int CMP_W = (SAMPLE_BITS + 2 > lst_pkg::THRESH_W + 1) ?
                         SAMPLE_BITS + 2 : lst_pkg::THRESH_W + 1;

  logic signed [CMP_W-1:0] code_s;
  logic signed [CMP_W-1:0] offset_s;
  logic signed [CMP_W-1:0] adjusted;
  logic signed [CMP_W-1:0] min_s;
  logic signed [CMP_W-1:0] max_s;

  // extend every operand to the compare width
  assign code_s   = signed'({{(CMP_W-SAMPLE_BITS){1'b0}}, code});
  assign offset_s = signed'({{(CMP_W-lst_pkg::OFFSET_W){offset[lst_pkg::OFFSET_W-1]}},
                             offset});
  assign min_s    = signed'({{(CMP_W-lst_pkg::THRESH_W){threshold_min[lst_pkg::THRESH_W-1]}},
                             threshold_min});
  assign max_s    = signed'({{(CMP_W-lst_pkg::THRESH_W){threshold_max[lst_pkg::THRESH_W-1]}},
                             threshold_max});

  // compare the adjusted code against the window
  assign adjusted = code_s + offset_s;
  assign active   = (adjusted >= min_s) && (adjusted <= max_s);

endmodule

FILE: hdl/lst_core.sv
// ----------------------------------------------------------------------------
// lst_core - tracker state, direction and debounced line counter
// Holds the sensor, position and counter state, steps it for each beat taken
// from the input register and forms the result from the updated state.
// ----------------------------------------------------------------------------
module lst_core #(
  parameter int SAMPLE_BITS = lst_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = lst_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [lst_pkg::CMD_W-1:0]     command,
  input  logic [SAMPLE_BITS-1:0]        sample_left,
  input  logic [SAMPLE_BITS-1:0]        sample_middle,
  input  logic [SAMPLE_BITS-1:0]        sample_right,
  input  logic [lst_pkg::TIME_W-1:0]    now_ms,
  input  logic [COUNT_BITS-1:0]         target_lines,
  input  lst_pkg::cfg_t                 cfg,
  output lst_pkg::status_t              status,
  output logic [COUNT_BITS-1:0]         line_count
);

  // state registers
  logic                        left_active, middle_active, right_active;
  logic [lst_pkg::POS_W-1:0]   position_state;
  logic [lst_pkg::DIR_W-1:0]   direction_state;
  logic                        previous_middle;
  logic                        counter_on;
  logic [COUNT_BITS-1:0]       count_value;
  logic [COUNT_BITS-1:0]       count_target;
  logic                        last_seen_middle;
  logic [lst_pkg::TIME_W-1:0]  last_trigger_time;

  logic                        left_active_next, middle_active_next, right_active_next;
  logic [lst_pkg::POS_W-1:0]   position_state_next;
  logic [lst_pkg::DIR_W-1:0]   direction_state_next;
  logic                        previous_middle_next;
  logic                        counter_on_next;
  logic [COUNT_BITS-1:0]       count_value_next;
  logic [COUNT_BITS-1:0]       count_target_next;
  logic                        last_seen_middle_next;
  logic [lst_pkg::TIME_W-1:0]  last_trigger_time_next;

  logic                        win_left, win_middle, win_right;
  logic [lst_pkg::TIME_W-1:0]  elapsed;
  logic                        trigger;
  logic                        crossed;

  // window compare per sensor
  lst_window #(.SAMPLE_BITS(SAMPLE_BITS)) u_win_left (
    .code(sample_left), .offset(cfg.offset_left),
    .threshold_min(cfg.threshold_min), .threshold_max(cfg.threshold_max),
    .active(win_left)
  );
  lst_window #(.SAMPLE_BITS(SAMPLE_BITS)) u_win_middle (
    .code(sample_middle), .offset(cfg.offset_middle),
    .threshold_min(cfg.threshold_min), .threshold_max(cfg.threshold_max),
    .active(win_middle)
  );
  lst_window #(.SAMPLE_BITS(SAMPLE_BITS)) u_win_right (
    .code(sample_right), .offset(cfg.offset_right),
    .threshold_min(cfg.threshold_min), .threshold_max(cfg.threshold_max),
    .active(win_right)
  );

  // debounce: time since the last accepted transition, wrapping
  assign elapsed = now_ms - last_trigger_time;
  assign trigger = (win_middle != last_seen_middle) &&
                   (elapsed > {{(lst_pkg::TIME_W-lst_pkg::DEB_W){1'b0}}, cfg.debounce_ms});

  // step the state for one command
  always_comb begin
    left_active_next       = left_active;
    middle_active_next     = middle_active;
    right_active_next      = right_active;
    position_state_next    = position_state;
    direction_state_next   = direction_state;
    previous_middle_next   = previous_middle;
    counter_on_next        = counter_on;
    count_value_next       = count_value;
    count_target_next      = count_target;
    last_seen_middle_next  = last_seen_middle;
    last_trigger_time_next = last_trigger_time;
    crossed                = 1'b0;
    case (command)
      lst_pkg::CMD_SAMPLE: begin
        left_active_next   = win_left;
        middle_active_next = win_middle;
        right_active_next  = win_right;
        // position machine; right wins over left from the middle
        case (position_state)
          lst_pkg::POS_LEFT: begin
            if (!win_left) position_state_next = lst_pkg::POS_MIDDLE;
          end
          lst_pkg::POS_RIGHT: begin
            if (!win_right) position_state_next = lst_pkg::POS_MIDDLE;
          end
          default: begin
            if (win_right)     position_state_next = lst_pkg::POS_RIGHT;
            else if (win_left) position_state_next = lst_pkg::POS_LEFT;
            else               position_state_next = lst_pkg::POS_MIDDLE;
          end
        endcase
        // priority direction
        if (win_middle)     direction_state_next = lst_pkg::DIR_FORWARD;
        else if (win_left)  direction_state_next = lst_pkg::DIR_LEFT;
        else if (win_right) direction_state_next = lst_pkg::DIR_RIGHT;
        else                direction_state_next = lst_pkg::DIR_LOST;
        crossed              = (win_middle != previous_middle);
        previous_middle_next = win_middle;
        // debounced rising-edge count, saturating; stop at the target
        if (counter_on) begin
          if (trigger) begin
            last_trigger_time_next = now_ms;
            last_seen_middle_next  = win_middle;
            if (win_middle && (count_value != {COUNT_BITS{1'b1}})) begin
              count_value_next = count_value + COUNT_BITS'(1'b1);
            end
          end
          if (count_value_next >= count_target) counter_on_next = 1'b0;
        end
      end
      lst_pkg::CMD_START: begin
        count_value_next      = '0;
        last_seen_middle_next = middle_active;
        count_target_next     = target_lines;
        counter_on_next       = 1'b1;
      end
      lst_pkg::CMD_STOP: begin
        counter_on_next  = 1'b0;
        count_value_next = '0;
      end
      default: begin
        counter_on_next = counter_on;
      end
    endcase
  end

  // advance the state on each beat taken
  always_ff @(posedge clk) begin
    if (rst) begin
      left_active       <= 1'b0;
      middle_active     <= 1'b0;
      right_active      <= 1'b0;
      position_state    <= lst_pkg::POS_MIDDLE;
      direction_state   <= lst_pkg::DIR_LOST;
      previous_middle   <= 1'b0;
      counter_on        <= 1'b0;
      count_value       <= '0;
      count_target      <= '0;
      last_seen_middle  <= 1'b0;
      last_trigger_time <= '0;
    end else if (advance) begin
      left_active       <= left_active_next;
      middle_active     <= middle_active_next;
      right_active      <= right_active_next;
      position_state    <= position_state_next;
      direction_state   <= direction_state_next;
      previous_middle   <= previous_middle_next;
      counter_on        <= counter_on_next;
      count_value       <= count_value_next;
      count_target      <= count_target_next;
      last_seen_middle  <= last_seen_middle_next;
      last_trigger_time <= last_trigger_time_next;
    end
  end

  // result from the updated state
  always_comb begin
    status.active_flags   = {right_active_next, middle_active_next, left_active_next};
    status.line_position  = position_state_next;
    status.direction      = direction_state_next;
    status.on_line        = middle_active_next && !left_active_next && !right_active_next;
    status.crossed        = crossed;
    status.counting       = counter_on_next;
    status.target_reached = !counter_on_next && (count_value_next >= count_target_next);
    line_count            = count_value_next;
  end

  // start clears the count and arms the counter
  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (advance && command == lst_pkg::CMD_START) |=> (counter_on && count_value == '0))
    else $error("start did not arm the counter");

  // a sample moves the count up by at most one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (advance && command == lst_pkg::CMD_SAMPLE) |=>
      (count_value == $past(count_value) ||
       count_value == $past(count_value) + COUNT_BITS'(1'b1)))
    else $error("line count jumped");

  // counting only ever turns on by a start command
  a_on_by_start: assert property (@(posedge clk) disable iff (rst)
    $rose(counter_on) |-> $past(advance && command == lst_pkg::CMD_START))
    else $error("counter turned on without start");

  // state holds while no beat is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(count_value) && $stable(position_state) && $stable(counter_on)))
    else $error("state moved without a beat");

endmodule

FILE: hdl/line_sensor_tracker.sv
// A result beat passes through the two register stages, the input register and
// then the result register, on its way from offer to result.
// Throughput: one beat per cycle; the input register and the result register
// each take a beat every cycle the downstream side accepts.
// Reset (rst, synchronous, active high) clears the tracker and counter state,
// empties both registers and loads the configuration registers' defaults.
// ----------------------------------------------------------------------------
// line_sensor_tracker - three-sensor line follower with debounced line counter
// Input register, tracker core and result register on stream channels, with
// a separate configuration write channel.
// ----------------------------------------------------------------------------
module line_sensor_tracker #(
  parameter int SAMPLE_BITS = lst_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = lst_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lst_pkg::REG_IDX_W-1:0]         cfg_index,
  input  logic [lst_pkg::CFG_DATA_W-1:0]        cfg_data,
  // input stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // s_tdata: sample_left, sample_middle, sample_right, now_ms, target_lines, zero pad
  input  logic [((3*SAMPLE_BITS+lst_pkg::TIME_W+COUNT_BITS+7)/8)*8-1:0] s_tdata,
  // s_tuser: command
  input  logic [lst_pkg::CMD_W-1:0]             s_tuser,
  // result stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // m_tdata: active_flags, line_position, direction, on_line, crossed, counting,
  //          line_count, target_reached, zero pad
  output logic [((11+COUNT_BITS+7)/8)*8-1:0]    m_tdata
);

  localparam int IN_DATA_W  = ((3*SAMPLE_BITS+lst_pkg::TIME_W+COUNT_BITS+7)/8)*8;
  localparam int OUT_W      = 11 + COUNT_BITS;
  localparam int OUT_DATA_W = ((OUT_W+7)/8)*8;
  localparam int MID_LO     = SAMPLE_BITS;
  localparam int RIGHT_LO   = 2*SAMPLE_BITS;
  localparam int TIME_LO    = 3*SAMPLE_BITS;
  localparam int TGT_LO     = TIME_LO + lst_pkg::TIME_W;

  lst_pkg::cfg_t                cfg;
  logic                         in_valid;
  logic [lst_pkg::CMD_W-1:0]    in_command;
  logic [SAMPLE_BITS-1:0]       in_left, in_middle, in_right;
  logic [lst_pkg::TIME_W-1:0]   in_now;
  logic [COUNT_BITS-1:0]        in_target;
  logic                         out_valid;
  lst_pkg::status_t             out_status;
  logic [COUNT_BITS-1:0]        out_count;
  lst_pkg::status_t             core_status;
  logic [COUNT_BITS-1:0]        core_count;
  logic                         out_free;
  logic                         advance;
  logic [OUT_W-1:0]             out_packed;

  // configuration writes are taken at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_min <= lst_pkg::THRESHOLD_MIN_RST;
      cfg.threshold_max <= lst_pkg::THRESHOLD_MAX_RST;
      cfg.offset_left   <= '0;
      cfg.offset_middle <= '0;
      cfg.offset_right  <= '0;
      cfg.debounce_ms   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lst_pkg::REG_THRESHOLD_MIN: cfg.threshold_min <= cfg_data[lst_pkg::THRESH_W-1:0];
        lst_pkg::REG_THRESHOLD_MAX: cfg.threshold_max <= cfg_data[lst_pkg::THRESH_W-1:0];
        lst_pkg::REG_OFFSET_LEFT:   cfg.offset_left   <= cfg_data[lst_pkg::OFFSET_W-1:0];
        lst_pkg::REG_OFFSET_MIDDLE: cfg.offset_middle <= cfg_data[lst_pkg::OFFSET_W-1:0];
        lst_pkg::REG_OFFSET_RIGHT:  cfg.offset_right  <= cfg_data[lst_pkg::OFFSET_W-1:0];
        lst_pkg::REG_DEBOUNCE_MS:   cfg.debounce_ms   <= cfg_data[lst_pkg::DEB_W-1:0];
        default: cfg.debounce_ms <= cfg.debounce_ms;
      endcase
    end
  end

  // handshake: the result register frees when empty or being taken
  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_command <= s_tuser;
      in_left    <= s_tdata[SAMPLE_BITS-1:0];
      in_middle  <= s_tdata[MID_LO +: SAMPLE_BITS];
      in_right   <= s_tdata[RIGHT_LO +: SAMPLE_BITS];
      in_now     <= s_tdata[TIME_LO +: lst_pkg::TIME_W];
      in_target  <= s_tdata[TGT_LO +: COUNT_BITS];
    end
  end

  lst_core #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_core (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .command(in_command),
    .sample_left(in_left),
    .sample_middle(in_middle),
    .sample_right(in_right),
    .now_ms(in_now),
    .target_lines(in_target),
    .cfg(cfg),
    .status(core_status),
    .line_count(core_count)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= core_status;
      out_count  <= core_count;
    end
  end

  // pack the result beat
  assign out_packed = {out_status.target_reached, out_count, out_status.counting,
                       out_status.crossed, out_status.on_line, out_status.direction,
                       out_status.line_position, out_status.active_flags};
  assign m_tdata  = OUT_DATA_W'(out_packed);
  assign m_tvalid = out_valid;

  // input data width is fixed by the field layout
  a_in_width: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> (IN_DATA_W >= TGT_LO + COUNT_BITS))
    else $error("input layout exceeds tdata");

  // a stalled result beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> (out_valid && $stable(out_packed)))
    else $error("result beat lost under stall");

  // every beat taken from the input register lands in the result register
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("beat dropped between stages");

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - stream-level testbench for the line sensor tracker
// Drives command and sample beats under random gaps and result back-pressure.
// Every accepted beat is run through a behavioural tracker model, and each
// result beat is compared field by field with the oldest pending report.
// A directed table comes first, then six random phases, each under its own
// register setting.
// ----------------------------------------------------------------------------
module tb_top;
  import lst_pkg::*;

  localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
  localparam int COUNT_BITS   = COUNT_BITS_DEF;
  localparam int S_TDATA_W    = ((3*SAMPLE_BITS+TIME_W+COUNT_BITS+7)/8)*8;
  localparam int M_TDATA_W    = ((11+COUNT_BITS+7)/8)*8;
  localparam int COUNT_MAX    = (1 << COUNT_BITS) - 1;
  localparam int PIPE_LATENCY = 2;
  localparam int PHASES       = 6;
  localparam int PHASE_BEATS  = 110;
  localparam int CYCLE_LIMIT  = 400000;

  // Command code the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One result beat, laid out as m_tdata from the top bit down
  typedef struct packed {
    logic             target_reached;
    logic [7:0]       line_count;
    logic             counting;
    logic             crossed;
    logic             on_line;
    logic [DIR_W-1:0] direction;
    logic [POS_W-1:0] line_position;
    logic [2:0]       active_flags;
  } report_t;

  typedef enum bit {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CMD_W-1:0]       cmd;
    logic [11:0]            code_l;
    logic [11:0]            code_m;
    logic [11:0]            code_r;
    logic [31:0]            now;
    logic [7:0]             tgt;
    logic                   typed;
    report_t                want;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
  } plan_row_t;

  // Reports that can be read straight off the reset state and the window
  localparam report_t NO_REPORT = '0;
  localparam report_t REP_RESET_STOP =
    '{1'b1, 8'd0, 1'b0, 1'b0, 1'b0, DIR_LOST, POS_MIDDLE, 3'b000};
  localparam report_t REP_FIRST_ALL_ON =
    '{1'b1, 8'd0, 1'b0, 1'b1, 1'b0, DIR_FORWARD, POS_RIGHT, 3'b111};
  localparam report_t REP_ALL_ON_HELD =
    '{1'b1, 8'd0, 1'b0, 1'b0, 1'b0, DIR_FORWARD, POS_RIGHT, 3'b111};
  localparam report_t REP_ALL_OFF =
    '{1'b1, 8'd0, 1'b0, 1'b1, 1'b0, DIR_LOST, POS_MIDDLE, 3'b000};

  // Directed table: window edges, every command, position moves, target of
  // zero, debounce rejection and time wrap
  localparam int PLAN_ROWS = 29;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_BEAT, CMD_STOP,   12'd0,    12'd0,    12'd0,    32'd0,  8'd0,   1'b1, REP_RESET_STOP,
      '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd0,    12'd0,    12'd0,    32'd0,  8'd0,   1'b1, REP_FIRST_ALL_ON,
      '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 8'd255, 1'b1,
      REP_ALL_ON_HELD, '0, '0},
    '{ROW_REG,  CMD_SAMPLE, '0, '0, '0, '0, '0, 1'b0, NO_REPORT, REG_THRESHOLD_MIN, 16'd100},
    '{ROW_REG,  CMD_SAMPLE, '0, '0, '0, '0, '0, 1'b0, NO_REPORT, REG_THRESHOLD_MAX, 16'd3000},
    '{ROW_BEAT, CMD_SAMPLE, 12'd0,    12'd0,    12'd0,    32'd1,   8'd0,  1'b1, REP_ALL_OFF,
      '0, '0},
    '{ROW_BEAT, CMD_START,  12'd0,    12'd0,    12'd0,    32'd0,   8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd0,    12'd1000, 12'd0,    32'd10,  8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_START,  12'd0,    12'd0,    12'd0,    32'd0,   8'd3,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd1000, 12'd0,    12'd0,    32'd11,  8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd1000, 12'd0,    12'd1000, 32'd12,  8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd0,    12'd0,    12'd1000, 32'd13,  8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd0,    12'd0,    12'd1000, 32'd14,  8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd1000, 12'd1000, 12'd1000, 32'd20,  8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd0,    12'd0,    12'd0,    32'd21,  8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd0,    12'd100,  12'd0,    32'd22,  8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd0,    12'd99,   12'd0,    32'd23,  8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd0,    12'd3000, 12'd0,    32'd24,  8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd0,    12'd3001, 12'd0,    32'd25,  8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_UNUSED, 12'd4095, 12'd4095, 12'd4095, 32'd26,  8'd7,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_START,  12'd0,    12'd0,    12'd0,    32'd0,   8'd255, 1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_STOP,   12'd0,    12'd0,    12'd0,    32'd0,   8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_REG,  CMD_SAMPLE, '0, '0, '0, '0, '0, 1'b0, NO_REPORT, REG_DEBOUNCE_MS, 16'd5},
    '{ROW_BEAT, CMD_START,  12'd0,    12'd0,    12'd0,    32'd0,   8'd2,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd0,    12'd1000, 12'd0,    32'd100, 8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd0,    12'd0,    12'd0,    32'd103, 8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd0,    12'd1000, 12'd0,    32'd105, 8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd0,    12'd0,    12'd0,    32'd106, 8'd0,  1'b0, NO_REPORT, '0, '0},
    '{ROW_BEAT, CMD_SAMPLE, 12'd0,    12'd1000, 12'd0,    32'hFFFF_FFF0, 8'd0, 1'b0, NO_REPORT,
      '0, '0}
  };

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [REG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata;
  logic [CMD_W-1:0]       s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_TDATA_W-1:0]   m_tdata;

  // Tracker model: registers and state
  int          thr_min   = 0;
  int          thr_max   = 4095;
  int          off_l     = 0;
  int          off_m     = 0;
  int          off_r     = 0;
  logic [31:0] deb_ms    = '0;
  bit          act_l     = 1'b0;
  bit          act_m     = 1'b0;
  bit          act_r     = 1'b0;
  logic [1:0]  pos_st    = POS_MIDDLE;
  logic [1:0]  dir_st    = DIR_LOST;
  bit          prev_m    = 1'b0;
  bit          count_on  = 1'b0;
  bit          seen_m    = 1'b0;
  int          lines     = 0;
  int          lines_tgt = 0;
  logic [31:0] last_trig = '0;

  report_t     pending_reports [$];
  int          errors = 0;
  bit          steady = 1'b0;
  int unsigned cycles = 0;

  line_sensor_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Window compare on the offset-adjusted code, both bounds inclusive
  function automatic bit in_window(input logic [11:0] code, input int off);
    int adj;
    adj = int'(code) + off;
    return (adj >= thr_min) && (adj <= thr_max);
  endfunction

  // Advance the tracker model by one beat and form its report
  function automatic report_t follow_line(input logic [CMD_W-1:0] cmd,
      input logic [11:0] code_l, input logic [11:0] code_m, input logic [11:0] code_r,
      input logic [31:0] now, input logic [7:0] tgt);
    report_t     rep;
    logic [31:0] since;
    rep = '0;
    if (cmd == CMD_SAMPLE) begin
      act_l = in_window(code_l, off_l);
      act_m = in_window(code_m, off_m);
      act_r = in_window(code_r, off_r);
      // position machine: right wins over left when leaving the middle
      case (pos_st)
        POS_LEFT: begin
          if (!act_l) pos_st = POS_MIDDLE;
        end
        POS_RIGHT: begin
          if (!act_r) pos_st = POS_MIDDLE;
        end
        default: begin
          pos_st = POS_MIDDLE;
          if (act_l) pos_st = POS_LEFT;
          if (act_r) pos_st = POS_RIGHT;
        end
      endcase
      if (act_m) dir_st = DIR_FORWARD;
      else if (act_l) dir_st = DIR_LEFT;
      else if (act_r) dir_st = DIR_RIGHT;
      else dir_st = DIR_LOST;
      rep.crossed = (act_m != prev_m);
      prev_m = act_m;
      // debounced rising-edge count, stopping once the target is met
      if (count_on) begin
        since = now - last_trig;
        if ((act_m != seen_m) && (since > deb_ms)) begin
          last_trig = now;
          seen_m = act_m;
          if (act_m && lines < COUNT_MAX) lines++;
        end
        if (lines >= lines_tgt) count_on = 1'b0;
      end
    end else if (cmd == CMD_START) begin
      lines = 0;
      seen_m = act_m;
      lines_tgt = int'(tgt);
      count_on = 1'b1;
    end else if (cmd == CMD_STOP) begin
      count_on = 1'b0;
      lines = 0;
    end
    rep.active_flags   = {act_r, act_m, act_l};
    rep.line_position  = pos_st;
    rep.direction      = dir_st;
    rep.on_line        = act_m && !act_l && !act_r;
    rep.counting       = count_on;
    rep.line_count     = lines[7:0];
    rep.target_reached = !count_on && (lines >= lines_tgt);
    return rep;
  endfunction

  // Random idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sensor code biased onto the window edges of the current setting
  function automatic logic [11:0] pick_code(input int off);
    int c;
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) c = ($urandom_range(0, 1) ? thr_min : thr_max) - off +
                   int'($urandom_range(0, 4)) - 2;
    else if (r == 5) c = $urandom_range(0, 1) ? 0 : 4095;
    else c = $urandom_range(0, 4095);
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return c[11:0];
  endfunction

  // Offer one beat, wait for it to be taken, then log what it should report
  task automatic drive_beat(input logic [CMD_W-1:0] cmd, input logic [11:0] code_l,
      input logic [11:0] code_m, input logic [11:0] code_r, input logic [31:0] now,
      input logic [7:0] tgt, input logic typed, input report_t want);
    int      gap;
    report_t rep;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= S_TDATA_W'({tgt, now, code_r, code_m, code_l});
    do @(posedge clk); while (!s_tready);
    rep = follow_line(cmd, code_l, code_m, code_r, now, tgt);
    pending_reports.push_back(typed ? want : rep);
  endtask

  // Drain the block, then write one register
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_THRESHOLD_MIN: thr_min = int'($signed(val[THRESH_W-1:0]));
      REG_THRESHOLD_MAX: thr_max = int'($signed(val[THRESH_W-1:0]));
      REG_OFFSET_LEFT:   off_l   = int'($signed(val[OFFSET_W-1:0]));
      REG_OFFSET_MIDDLE: off_m   = int'($signed(val[OFFSET_W-1:0]));
      REG_OFFSET_RIGHT:  off_r   = int'($signed(val[OFFSET_W-1:0]));
      REG_DEBOUNCE_MS:   deb_ms  = {16'd0, val[DEB_W-1:0]};
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Compare a result beat with the oldest pending report
  task automatic check_report(input report_t got);
    report_t want;
    if (pending_reports.size() == 0) begin
      $error("result beat %h arrived with no report pending", got);
      errors++;
    end else begin
      want = pending_reports.pop_front();
      cmp_field("active_flags",   32'(want.active_flags),   32'(got.active_flags));
      cmp_field("line_position",  32'(want.line_position),  32'(got.line_position));
      cmp_field("direction",      32'(want.direction),      32'(got.direction));
      cmp_field("on_line",        32'(want.on_line),        32'(got.on_line));
      cmp_field("crossed",        32'(want.crossed),        32'(got.crossed));
      cmp_field("counting",       32'(want.counting),       32'(got.counting));
      cmp_field("line_count",     32'(want.line_count),     32'(got.line_count));
      cmp_field("target_reached", 32'(want.target_reached), 32'(got.target_reached));
    end
  endtask

  // Result side: check each taken beat, stall at random
  initial begin : result_sink
    int hold;
    hold = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) check_report(report_t'(m_tdata[18:0]));
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        hold = idle_len();
      end
    end
  end

  // Watchdog on the whole run
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int          setting [6];
    logic [31:0] clock_ms;
    logic [CMD_W-1:0] cmd;
    logic [7:0]  tgt;
    int          r;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_SAMPLE;
    clock_ms  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_REG) write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
      else drive_beat(PLAN[i].cmd, PLAN[i].code_l, PLAN[i].code_m, PLAN[i].code_r,
                      PLAN[i].now, PLAN[i].tgt, PLAN[i].typed, PLAN[i].want);
    end

    // Random phases, each under a fresh register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: setting = '{-4095, 8190, -4095, 4095, 0, 65535};
        1: setting = '{8190, 8190, 4095, 4095, 4095, 0};
        2: setting = '{-4095, -4095, -4095, -4095, -4095, 1};
        default: begin
          setting[0] = int'($urandom_range(0, 5000)) - 1000;
          setting[1] = setting[0] + int'($urandom_range(0, 3000));
          // now and then an empty window
          if ($urandom_range(0, 5) == 0) setting[1] = setting[0] - 1;
          for (int k = 2; k < 5; k++) setting[k] = int'($urandom_range(0, 8190)) - 4095;
          setting[5] = $urandom_range(0, 30);
        end
      endcase
      for (int k = 0; k < 6; k++) write_reg(k[REG_IDX_W-1:0], setting[k][CFG_DATA_W-1:0]);

      for (int n = 0; n < PHASE_BEATS; n++) begin
        // open each phase with a stretch at full rate
        steady = (n < 25);
        r = $urandom_range(0, 99);
        if (r < 86) cmd = CMD_SAMPLE;
        else if (r < 93) cmd = CMD_START;
        else if (r < 98) cmd = CMD_STOP;
        else cmd = CMD_UNUSED;
        if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
        else clock_ms = clock_ms + $urandom_range(0, deb_ms + 12);
        r = $urandom_range(0, 19);
        if (r < 14) tgt = 8'($urandom_range(1, 8));
        else if (r < 17) tgt = 8'd0;
        else tgt = 8'($urandom_range(0, 255));
        drive_beat(cmd, pick_code(off_l), pick_code(off_m), pick_code(off_r),
                   clock_ms, tgt, 1'b0, NO_REPORT);
      end
      steady = 1'b0;
    end

    // Drain and finish
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (errors == 0 && pending_reports.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: line_sensor_tracker.f
hdl/lst_pkg.sv
hdl/lst_window.sv
hdl/lst_core.sv
hdl/line_sensor_tracker.sv
dv/tb_top.sv
